>>> design/allm_pkg.sv
// Shared types and constants for the array linked-list manager.
// Holds command, status and emit codes plus the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package allm_pkg;

    // Field widths of the stream payloads.
    localparam int CMD_W     = 2;
    localparam int ITEM_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int LOC_W     = 5;
    localparam int COUNT_W   = 6;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    // A dump never gives more results than this.
    localparam int OUT_LIMIT = 32;

    typedef enum logic [1:0] {
        CMD_INS_HEAD = 2'd0,
        CMD_INS_TAIL = 2'd1,
        CMD_SEARCH   = 2'd2,
        CMD_DUMP     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    // Which result the datapath loads into its output register.
    typedef enum logic [2:0] {
        EM_FULL  = 3'd0,
        EM_NEW   = 3'd1,
        EM_FOUND = 3'd2,
        EM_MISS  = 3'd3,
        EM_EMPTY = 3'd4,
        EM_NODE  = 3'd5
    } emit_kind_t;

    // Controller to datapath.
    typedef struct packed {
        logic       latch_in;
        logic       wr_new;
        logic       link_to_head;
        logic       set_head;
        logic       inc_count;
        logic       start_walk;
        logic       step_walk;
        logic       link_tail;
        logic       emit;
        emit_kind_t kind;
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        cmd_t cmd;
        logic full;
        logic list_empty;
        logic match;
        logic link_node;
        logic walk_last;
        logic steps_full;
        logic dump_fin;
        logic out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

>>> design/allm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the node value and next-link arrays. No dependencies.
`default_nettype none

module allm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> design/allm_dpath.sv
// Datapath of the linked-list manager: node memories, list head, element count,
// walk pointer and the output register. Depends on allm_pkg and allm_ram.
`default_nettype none

module allm_dpath
    import allm_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic      [M_TDATA_W-1:0] m_tdata,
    output logic                      m_tlast,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire dp_cmd_t              cmd,
    output dp_sts_t                   sts
);

    localparam int IW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam logic [LW-1:0] NULL_LINK = LW'(DEPTH);
    localparam logic [LW-1:0] LAST_STEP = LW'(DEPTH - 1);

    cmd_t              cmd_reg,   cmd_next;
    logic [ITEM_W-1:0] item_reg,  item_next;
    logic [LW-1:0]     head_reg,  head_next;
    logic [LW-1:0]     cnt_reg,   cnt_next;
    logic [IW-1:0]     p_reg,     p_next;
    logic [LW-1:0]     steps_reg, steps_next;

    logic                out_valid_reg,  out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [LOC_W-1:0]    out_loc_reg,    out_loc_next;
    logic [ITEM_W-1:0]   out_value_reg,  out_value_next;
    logic [COUNT_W-1:0]  out_count_reg,  out_count_next;
    logic                out_last_reg,   out_last_next;

    logic [ITEM_W-1:0] val_rdata;
    logic [LW-1:0]     link_rdata;
    logic [IW-1:0]     new_node;
    logic [IW-1:0]     walk_addr;
    logic              link_wr_en;
    logic [IW-1:0]     link_wr_addr;
    logic [LW-1:0]     link_wr_data;
    logic              rd_en;
    logic [LW-1:0]     cnt_inc;
    logic              link_node;
    logic              walk_last;
    logic              at_cap;
    logic              dump_fin;

    // Nodes are never released, so the free chain is simply the next unused index.
    assign new_node  = cnt_reg[IW-1:0];
    assign cnt_inc   = cnt_reg + LW'(1);
    assign link_node = link_rdata < NULL_LINK;
    assign walk_last = steps_reg == LAST_STEP;
    assign at_cap    = 8'(steps_reg) == 8'(OUT_LIMIT - 1);
    assign dump_fin  = !link_node || walk_last || at_cap;

    assign rd_en     = cmd.start_walk || cmd.step_walk;
    assign walk_addr = cmd.start_walk ? head_reg[IW-1:0] : link_rdata[IW-1:0];

    assign link_wr_en   = cmd.wr_new || cmd.link_tail;
    assign link_wr_addr = cmd.link_tail ? p_reg : new_node;
    always_comb
    begin
        if (cmd.link_tail)
        begin
            link_wr_data = LW'(new_node);
        end
        else if (cmd.link_to_head)
        begin
            link_wr_data = head_reg;
        end
        else
        begin
            link_wr_data = NULL_LINK;
        end
    end

    allm_ram #(
        .WIDTH (ITEM_W),
        .DEPTH (DEPTH)
    ) u_values (
        .clk     (clk),
        .wr_en   (cmd.wr_new),
        .wr_addr (new_node),
        .wr_data (item_reg),
        .rd_en   (rd_en),
        .rd_addr (walk_addr),
        .rd_data (val_rdata)
    );

    allm_ram #(
        .WIDTH (LW),
        .DEPTH (DEPTH)
    ) u_links (
        .clk     (clk),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data),
        .rd_en   (rd_en),
        .rd_addr (walk_addr),
        .rd_data (link_rdata)
    );

    // Input capture, list head, count and walk pointer.
    always_comb
    begin
        cmd_next   = cmd.latch_in ? cmd_t'(s_tdata[CMD_W-1:0]) : cmd_reg;
        item_next  = cmd.latch_in ? s_tdata[CMD_W +: ITEM_W] : item_reg;
        head_next  = cmd.set_head ? LW'(new_node) : head_reg;
        cnt_next   = cmd.inc_count ? cnt_inc : cnt_reg;
        p_next     = p_reg;
        steps_next = steps_reg;
        if (cmd.start_walk)
        begin
            p_next     = head_reg[IW-1:0];
            steps_next = '0;
        end
        else if (cmd.step_walk)
        begin
            p_next     = link_rdata[IW-1:0];
            steps_next = steps_reg + LW'(1);
        end
    end

    // Output register.
    always_comb
    begin
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_loc_next    = out_loc_reg;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_count_next = COUNT_W'(cmd.inc_count ? cnt_inc : cnt_reg);
            out_last_next  = 1'b1;
            out_loc_next   = '0;
            out_value_next = '0;
            case (cmd.kind)
                EM_FULL:
                begin
                    out_status_next = ST_OVERFLOW;
                end
                EM_NEW:
                begin
                    out_status_next = ST_OK;
                    out_loc_next    = LOC_W'(new_node);
                    out_value_next  = item_reg;
                end
                EM_FOUND:
                begin
                    out_status_next = ST_OK;
                    out_loc_next    = LOC_W'(p_reg);
                    out_value_next  = item_reg;
                end
                EM_MISS:
                begin
                    out_status_next = ST_NOT_FOUND;
                end
                EM_EMPTY:
                begin
                    out_status_next = ST_EMPTY;
                end
                EM_NODE:
                begin
                    out_status_next = ST_OK;
                    out_loc_next    = LOC_W'(p_reg);
                    out_value_next  = val_rdata;
                    out_last_next   = dump_fin;
                end
                default:
                begin
                    out_status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= NULL_LINK;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        item_reg       <= item_next;
        p_reg          <= p_next;
        steps_reg      <= steps_next;
        out_status_reg <= out_status_next;
        out_loc_reg    <= out_loc_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tdata  = {3'b000, out_count_reg, out_value_reg, out_loc_reg, out_status_reg};
    assign m_tlast  = out_last_reg;
    assign m_tvalid = out_valid_reg;

    assign sts.cmd        = cmd_reg;
    assign sts.full       = cnt_reg == NULL_LINK;
    assign sts.list_empty = head_reg == NULL_LINK;
    assign sts.match      = val_rdata == item_reg;
    assign sts.link_node  = link_node;
    assign sts.walk_last  = walk_last;
    assign sts.steps_full = steps_reg == NULL_LINK;
    assign sts.dump_fin   = dump_fin;
    assign sts.out_free   = !out_valid_reg || m_tready;

endmodule

`default_nettype wire

>>> design/allm_ctrl.sv
// Controller state machine of the linked-list manager.
// Sequences dispatch, list walks and result emission. Depends on allm_pkg.
`default_nettype none

module allm_ctrl
    import allm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_DISPATCH  = 6'b000010,
        S_TAIL_WALK = 6'b000100,
        S_TAIL_LINK = 6'b001000,
        S_SEARCH    = 6'b010000,
        S_DUMP      = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.kind   = EM_NEW;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready     = 1'b1;
                cmd.latch_in = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.cmd)
                    CMD_INS_HEAD, CMD_INS_TAIL:
                    begin
                        if (sts.full)
                        begin
                            cmd.kind = EM_FULL;
                            cmd.emit = sts.out_free;
                            if (sts.out_free)
                            begin
                                state_next = S_IDLE;
                            end
                        end
                        else if (sts.cmd == CMD_INS_HEAD || sts.list_empty)
                        begin
                            // The new node becomes the head in one step.
                            if (sts.out_free)
                            begin
                                cmd.wr_new       = 1'b1;
                                cmd.link_to_head = sts.cmd == CMD_INS_HEAD;
                                cmd.set_head     = 1'b1;
                                cmd.inc_count    = 1'b1;
                                cmd.emit         = 1'b1;
                                state_next       = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.wr_new     = 1'b1;
                            cmd.start_walk = 1'b1;
                            state_next     = S_TAIL_WALK;
                        end
                    end
                    CMD_SEARCH:
                    begin
                        if (sts.list_empty)
                        begin
                            cmd.kind = EM_MISS;
                            cmd.emit = sts.out_free;
                            if (sts.out_free)
                            begin
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.start_walk = 1'b1;
                            state_next     = S_SEARCH;
                        end
                    end
                    CMD_DUMP:
                    begin
                        if (sts.list_empty)
                        begin
                            cmd.kind = EM_EMPTY;
                            cmd.emit = sts.out_free;
                            if (sts.out_free)
                            begin
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.start_walk = 1'b1;
                            state_next     = S_DUMP;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_TAIL_WALK:
            begin
                if (sts.link_node && !sts.steps_full)
                begin
                    cmd.step_walk = 1'b1;
                end
                else
                begin
                    state_next = S_TAIL_LINK;
                end
            end
            S_TAIL_LINK:
            begin
                if (sts.out_free)
                begin
                    cmd.link_tail = 1'b1;
                    cmd.inc_count = 1'b1;
                    cmd.emit      = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_SEARCH:
            begin
                if (sts.match)
                begin
                    cmd.kind = EM_FOUND;
                    cmd.emit = sts.out_free;
                    if (sts.out_free)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (!sts.link_node || sts.walk_last)
                begin
                    cmd.kind = EM_MISS;
                    cmd.emit = sts.out_free;
                    if (sts.out_free)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.step_walk = 1'b1;
                end
            end
            S_DUMP:
            begin
                cmd.kind = EM_NODE;
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.dump_fin)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.step_walk = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> design/array_linked_list_manager.sv
// Top level of the array-based linked-list manager.
// Instantiates allm_ctrl and allm_dpath; uses types from allm_pkg.
//
// The block keeps a singly linked list in a pool of DEPTH nodes, held in two
// small RAMs (values and next links), and takes one command per item: insert
// at head, insert at tail, search for a value, or dump the list in order.
// Every result carries the element count after the command and the last flag
// marks the final result of a command. Commands are handled one at a time. An
// insert at head, any insert into an empty list, an insert into a full pool
// and any command on an empty list need no walk. An insert at tail, a search
// and a dump walk the list through the link RAM at one node per cycle, a dump
// only while the output is taken. A dump gives one result per cycle while the
// output is taken. Back pressure on the output simply pauses a dump walk. Since
// nodes are never released, no pass over the RAMs is needed after reset: only
// entries that have been written are ever read, and the block is ready right
// after reset.
`default_nettype none

module array_linked_list_manager
    import allm_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // s_tdata: cmd [1:0], item [33:2], zero pad [39:34].
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // m_tdata: status [1:0], location [6:2], value [38:7],
    // element_count [44:39], zero pad [47:45].
    output logic      [M_TDATA_W-1:0] m_tdata,
    output logic                      m_tlast,
    output logic                      m_tvalid,
    input  wire logic                 m_tready
);

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    allm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (dp_sts),
        .cmd      (dp_cmd)
    );

    allm_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (dp_cmd),
        .sts      (dp_sts)
    );

endmodule

`default_nettype wire
